FILE: src/pcs_pkg.sv
`default_nettype none

package pcs_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLR,
        S_CHK_RD,
        S_CHK_MK,
        S_CHK_EV,
        S_WK_POS,
        S_WK_PCHK,
        S_WK_STEP_CUR
    } state_t;

    // walk reuses one more state for the cursor mark test
    typedef enum logic {
        WK_STEP,
        WK_CUR
    } walk_phase_t;

    // classification of one incoming entry
    typedef struct packed {
        logic count_inc;
        logic store_en;
        logic bad;
    } entry_status_t;

    localparam logic [1:0] SIGN_ZERO = 2'b00;
    localparam logic [1:0] SIGN_POS  = 2'b01;
    localparam logic [1:0] SIGN_NEG  = 2'b11;

    localparam logic [31:0] MISSING_MARK = 32'h8000_0000;

endpackage

`default_nettype wire

FILE: src/pcs_entry_check.sv
`default_nettype none

module pcs_entry_check
    import pcs_pkg::*;
#(
    parameter int MAX_N = 1024
) (
    input  wire logic [31:0]              element_value,
    input  wire logic [31:0]              index_offset,
    input  wire logic [$clog2(MAX_N):0]   count,
    output entry_status_t                 status,
    output logic [$clog2(MAX_N)-1:0]      entry_index
);

    localparam int AW = $clog2(MAX_N);

    logic [32:0] diff;
    logic        missing;
    logic        out_of_range;
    logic        full;

    // exact 33-bit shifted entry, never wraps
    assign diff = {element_value[31], element_value} - {index_offset[31], index_offset};

    assign missing      = (element_value == MISSING_MARK);
    assign out_of_range = diff[32] || (diff >= 33'(MAX_N));
    assign full         = (count >= (AW+1)'(MAX_N));

    // entries past the store depth are dropped but still spoil the vector
    always_comb
    begin
        status.count_inc = !full;
        status.store_en  = !full && !missing && !out_of_range;
        status.bad       = full || missing || out_of_range;
    end

    assign entry_index = diff[AW-1:0];

endmodule

`default_nettype wire

FILE: src/permutation_check_and_sign.sv
// Permutation check and sign. Entries arrive one per transaction (start high while busy
// is low), the last one flagged by last_element; index_offset is subtracted from each.
// The block stays idle while loading, so entries may follow back to back. After the last
// entry a check pass reads each entry from the entry store and then its visited mark
// (states S_CHK_MK and S_CHK_EV), then a cycle walk tests the mark of each position
// (S_WK_POS, S_WK_PCHK) and of each step inside a cycle (WK_STEP, WK_CUR). An invalid
// vector found while loading answers in the next cycle, one found in the check pass after
// a clearing sweep of the marks of its n entries. Both memories have one read port with a
// registered output. After reset busy stays high while all MAX_N marks are swept clear.
// The result is shown on done for exactly one cycle and cannot be held off; sign is +1
// (01) or -1 (11), and 0 with is_permutation low.
`default_nettype none

module permutation_check_and_sign
    import pcs_pkg::*;
#(
    parameter int MAX_N = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] element_value,
    input  wire logic        last_element,
    input  wire logic        index_offset_we,
    input  wire logic [31:0] index_offset,
    output logic             done,
    output logic             is_permutation,
    output logic [1:0]       permutation_sign
);

    localparam int AW = $clog2(MAX_N);

    state_t        state_reg, state_next;
    walk_phase_t   phase_reg, phase_next;
    logic [31:0]   offset_reg;
    logic [AW:0]   count_reg, count_next;
    logic [AW:0]   pos_reg, pos_next;
    logic          invalid_reg, invalid_next;
    logic          sign_neg_reg, sign_neg_next;
    logic          clr_all_reg, clr_all_next;
    logic          done_reg, done_next;
    logic          is_perm_reg, is_perm_next;
    logic [1:0]    sign_reg, sign_next;

    // memory ports
    logic [AW-1:0] store_mem [MAX_N];
    logic          mark_mem  [MAX_N];
    logic          store_we, store_re;
    logic [AW-1:0] store_wa, store_wd, store_ra, store_q;
    logic          mark_we, mark_wd, mark_re, mark_q;
    logic [AW-1:0] mark_wa, mark_ra;

    entry_status_t entry_status;
    logic [AW-1:0] entry_index;
    logic [AW:0]   pos_inc;
    logic [AW:0]   clr_limit;

    // entry classification
    pcs_entry_check #(
        .MAX_N (MAX_N)
    ) u_entry_check (
        .element_value (element_value),
        .index_offset  (offset_reg),
        .count         (count_reg),
        .status        (entry_status),
        .entry_index   (entry_index)
    );

    // offset register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offset_reg <= '0;
        else if (index_offset_we)
            offset_reg <= index_offset;
    end

    // entry store, contents undefined until written
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[store_wa] <= store_wd;
        if (store_re)
            store_q <= store_mem[store_ra];
    end

    // visited marks, swept clear after reset
    always_ff @(posedge clk)
    begin
        if (mark_we)
            mark_mem[mark_wa] <= mark_wd;
        if (mark_re)
            mark_q <= mark_mem[mark_ra];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            phase_reg    <= WK_STEP;
            count_reg    <= '0;
            pos_reg      <= '0;
            invalid_reg  <= 1'b0;
            sign_neg_reg <= 1'b0;
            clr_all_reg  <= 1'b1;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            pos_reg      <= pos_next;
            invalid_reg  <= invalid_next;
            sign_neg_reg <= sign_neg_next;
            clr_all_reg  <= clr_all_next;
            done_reg     <= done_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        is_perm_reg <= is_perm_next;
        sign_reg    <= sign_next;
    end

    assign pos_inc   = pos_reg + (AW+1)'(1);
    assign clr_limit = clr_all_reg ? (AW+1)'(MAX_N) : count_reg;

    // sequencer: load, check pass, cycle walk, clearing sweep
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        invalid_next  = invalid_reg;
        sign_neg_next = sign_neg_reg;
        clr_all_next  = clr_all_reg;
        done_next     = 1'b0;
        is_perm_next  = is_perm_reg;
        sign_next     = sign_reg;
        store_we      = 1'b0;
        store_wa      = count_reg[AW-1:0];
        store_wd      = entry_index;
        store_re      = 1'b0;
        store_ra      = pos_reg[AW-1:0];
        mark_we       = 1'b0;
        mark_wa       = pos_reg[AW-1:0];
        mark_wd       = 1'b0;
        mark_re       = 1'b0;
        mark_ra       = pos_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    store_we     = entry_status.store_en;
                    invalid_next = invalid_reg || entry_status.bad;
                    if (entry_status.count_inc)
                        count_next = count_reg + (AW+1)'(1);
                    if (last_element)
                    begin
                        pos_next = '0;
                        if (invalid_reg || entry_status.bad)
                        begin
                            done_next    = 1'b1;
                            is_perm_next = 1'b0;
                            sign_next    = SIGN_ZERO;
                            count_next   = '0;
                            invalid_next = 1'b0;
                        end
                        else
                        begin
                            state_next = S_CHK_RD;
                        end
                    end
                end
            end

            S_CLR:
            begin
                mark_we  = 1'b1;
                pos_next = pos_inc;
                if (pos_inc == clr_limit)
                begin
                    state_next = S_IDLE;
                    pos_next   = '0;
                    if (!clr_all_reg)
                    begin
                        done_next    = 1'b1;
                        is_perm_next = 1'b0;
                        sign_next    = SIGN_ZERO;
                    end
                    clr_all_next  = 1'b0;
                    count_next    = '0;
                    invalid_next  = 1'b0;
                    sign_neg_next = 1'b0;
                end
            end

            S_CHK_RD:
            begin
                store_re   = 1'b1;
                state_next = S_CHK_MK;
            end

            S_CHK_MK:
            begin
                if ({1'b0, store_q} >= count_reg)
                begin
                    state_next = S_CLR;
                    pos_next   = '0;
                end
                else
                begin
                    mark_re    = 1'b1;
                    mark_ra    = store_q;
                    state_next = S_CHK_EV;
                end
            end

            S_CHK_EV:
            begin
                if (mark_q)
                begin
                    // repeated entry
                    state_next = S_CLR;
                    pos_next   = '0;
                end
                else
                begin
                    mark_we  = 1'b1;
                    mark_wa  = store_q;
                    mark_wd  = 1'b1;
                    pos_next = pos_inc;
                    if (pos_inc == count_reg)
                    begin
                        state_next = S_WK_POS;
                        pos_next   = '0;
                    end
                    else
                    begin
                        store_re   = 1'b1;
                        store_ra   = pos_inc[AW-1:0];
                        state_next = S_CHK_MK;
                    end
                end
            end

            // marks now read 1 for unvisited, the walk clears them
            S_WK_POS:
            begin
                if (pos_reg == count_reg)
                begin
                    done_next     = 1'b1;
                    is_perm_next  = 1'b1;
                    sign_next     = sign_neg_reg ? SIGN_NEG : SIGN_POS;
                    state_next    = S_IDLE;
                    pos_next      = '0;
                    count_next    = '0;
                    invalid_next  = 1'b0;
                    sign_neg_next = 1'b0;
                end
                else
                begin
                    mark_re    = 1'b1;
                    state_next = S_WK_PCHK;
                end
            end

            S_WK_PCHK:
            begin
                if (!mark_q)
                begin
                    pos_next   = pos_inc;
                    state_next = S_WK_POS;
                end
                else
                begin
                    mark_we    = 1'b1;
                    store_re   = 1'b1;
                    phase_next = WK_STEP;
                    state_next = S_WK_STEP_CUR;
                end
            end

            S_WK_STEP_CUR:
            begin
                unique case (phase_reg)
                    WK_STEP:
                    begin
                        mark_re    = 1'b1;
                        mark_ra    = store_q;
                        phase_next = WK_CUR;
                    end
                    WK_CUR:
                    begin
                        if (mark_q)
                        begin
                            sign_neg_next = !sign_neg_reg;
                            mark_we       = 1'b1;
                            mark_wa       = store_q;
                            store_re      = 1'b1;
                            store_ra      = store_q;
                            phase_next    = WK_STEP;
                        end
                        else
                        begin
                            pos_next   = pos_inc;
                            phase_next = WK_STEP;
                            state_next = S_WK_POS;
                        end
                    end
                    default:
                    begin
                        phase_next = WK_STEP;
                    end
                endcase
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy             = (state_reg != S_IDLE);
    assign done             = done_reg;
    assign is_permutation   = is_perm_reg;
    assign permutation_sign = sign_reg;

endmodule

`default_nettype wire

FILE: src/pcs_checker.sv
`default_nettype none

module pcs_checker
    import pcs_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [31:0] element_value,
    input wire logic        last_element,
    input wire logic        done,
    input wire logic        is_permutation,
    input wire logic [1:0]  permutation_sign
);

    // an invalid vector carries a zero sign
    a_zero_sign_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        done && !is_permutation |-> permutation_sign == SIGN_ZERO)
        else $error("invalid result with non-zero sign");

    // a valid vector carries +1 or -1
    a_unit_sign_when_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done && is_permutation |-> permutation_sign == SIGN_POS || permutation_sign == SIGN_NEG)
        else $error("valid result with bad sign code");

    // while idle only a final transaction can raise a result next cycle
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !(start && last_element) |=> !done)
        else $error("result without a final transaction");

    // a missing marker as final entry answers invalid at once
    a_missing_last_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last_element && element_value == MISSING_MARK
        |=> done && !is_permutation)
        else $error("missing marker not reported as invalid");

endmodule

bind permutation_check_and_sign pcs_checker u_pcs_checker (.*);

`default_nettype wire

FILE: tb/perm_sign_checker.sv
`default_nettype none

module perm_sign_checker
    import pcs_pkg::*;
#(
    parameter int MAX_N = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [31:0] element_value,
    input  wire logic        last_element,
    input  wire logic        index_offset_we,
    input  wire logic [31:0] index_offset,
    input  wire logic        done,
    input  wire logic        is_permutation,
    input  wire logic [1:0]  permutation_sign,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W = $clog2(MAX_N);

    typedef struct packed {
        logic       valid;
        logic [1:0] sign;
    } outcome_t;

    // expected outcomes, oldest first
    outcome_t expected_outcomes [$];

    // shadow of the vector being loaded
    logic [IDX_W-1:0] entry_store [0:MAX_N-1];
    int unsigned      entry_count;
    bit               vector_bad;
    logic [31:0]      offset_reg;
    longint           shifted;
    outcome_t         got;
    outcome_t         want;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        fail_count++;
    endtask

    // range and repetition check, then parity from the number of cycles
    function automatic outcome_t predict_outcome(input int unsigned n, input bit bad);
        logic [MAX_N-1:0] seen;
        int unsigned      i;
        int unsigned      cur;
        int unsigned      cycles;
        outcome_t         res;
        seen = '0;
        cycles = 0;
        if (!bad)
        begin
            for (i = 0; i < n; i++)
            begin
                if (entry_store[i] >= n || seen[entry_store[i]])
                begin
                    bad = 1'b1;
                    break;
                end
                seen[entry_store[i]] = 1'b1;
            end
        end
        if (bad)
        begin
            res.valid = 1'b0;
            res.sign  = SIGN_ZERO;
            return res;
        end
        seen = '0;
        for (i = 0; i < n; i++)
        begin
            if (!seen[i])
            begin
                cycles++;
                cur = i;
                while (!seen[cur])
                begin
                    seen[cur] = 1'b1;
                    cur = entry_store[cur];
                end
            end
        end
        res.valid = 1'b1;
        res.sign  = ((n - cycles) % 2 != 0) ? SIGN_NEG : SIGN_POS;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_outcomes.delete();
            entry_count = 0;
            vector_bad  = 1'b0;
            offset_reg  = '0;
            fail_count  = 0;
            pending    <= 0;
        end
        else
        begin
            // result transaction against the oldest expectation
            if (done)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    report_mismatch("result with nothing expected");
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    got.valid = is_permutation;
                    got.sign  = permutation_sign;
                    if (got.valid !== want.valid)
                        report_mismatch($sformatf("is_permutation %b, expected %b",
                                                  got.valid, want.valid));
                    if (got.sign !== want.sign)
                        report_mismatch($sformatf("permutation_sign %b, expected %b",
                                                  got.sign, want.sign));
                end
            end

            // input transaction
            if (start && !busy)
            begin
                if (entry_count >= MAX_N)
                begin
                    vector_bad = 1'b1;
                end
                else
                begin
                    shifted = longint'($signed(element_value)) - longint'($signed(offset_reg));
                    if (element_value == MISSING_MARK || shifted < 0 || shifted >= MAX_N)
                        vector_bad = 1'b1;
                    else
                        entry_store[entry_count] = shifted[IDX_W-1:0];
                    entry_count++;
                end
                if (last_element)
                begin
                    expected_outcomes.push_back(predict_outcome(entry_count, vector_bad));
                    entry_count = 0;
                    vector_bad  = 1'b0;
                end
            end

            // offset register write
            if (index_offset_we)
                offset_reg = index_offset;

            pending <= expected_outcomes.size();
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

module tb
    import pcs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_N           = 1024;
    localparam int PHASE_COUNT     = 8;
    localparam int ITEMS_PER_PHASE = 60;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] element_value;
    logic        last_element;
    logic        index_offset_we;
    logic [31:0] index_offset;
    logic        done;
    logic        is_permutation;
    logic [1:0]  permutation_sign;
    int          fail_count;
    int          pending;

    // entries of the next vector to send
    logic [31:0] vec_q [$];
    bit          quiet;

    permutation_check_and_sign #(.MAX_N(MAX_N)) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .element_value    (element_value),
        .last_element     (last_element),
        .index_offset_we  (index_offset_we),
        .index_offset     (index_offset),
        .done             (done),
        .is_permutation   (is_permutation),
        .permutation_sign (permutation_sign)
    );

    perm_sign_checker #(.MAX_N(MAX_N)) u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .element_value    (element_value),
        .last_element     (last_element),
        .index_offset_we  (index_offset_we),
        .index_offset     (index_offset),
        .done             (done),
        .is_permutation   (is_permutation),
        .permutation_sign (permutation_sign),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // overall time limit
    initial
    begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // one transaction per entry, with random gaps on the sender side
    task automatic send_vec();
        int k;
        for (k = 0; k < vec_q.size(); k++)
        begin
            start         <= 1'b1;
            element_value <= vec_q[k];
            last_element  <= (k == vec_q.size() - 1);
            do @(posedge clk); while (busy);
            if (!quiet && $urandom_range(99) < 10)
            begin
                start         <= 1'b0;
                element_value <= $urandom;
                last_element  <= 1'($urandom_range(1));
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
        end
    endtask

    // hold the sender until every outcome is back and the block is idle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic set_offset(input logic [31:0] value);
        drain();
        index_offset_we <= 1'b1;
        index_offset    <= value;
        @(posedge clk);
        index_offset_we <= 1'b0;
    endtask

    // shuffled 0..n-1 shifted by the offset (wraps for extreme offsets)
    task automatic build_perm(input int n, input logic [31:0] off);
        int          k;
        int          r;
        logic [31:0] tmp;
        vec_q.delete();
        for (k = 0; k < n; k++)
            vec_q.push_back(k + off);
        for (k = n - 1; k > 0; k--)
        begin
            r        = $urandom_range(k);
            tmp      = vec_q[k];
            vec_q[k] = vec_q[r];
            vec_q[r] = tmp;
        end
    endtask

    // spoil a well-formed vector in one of several ways
    task automatic break_vec(input int kind, input logic [31:0] off);
        int n;
        int a;
        int k;
        n = vec_q.size();
        a = $urandom_range(n - 1);
        case (kind)
            0:
            begin
                if (n >= 2)
                    vec_q[a] = vec_q[(a + 1) % n];
                else
                    vec_q[a] = off + 1;
            end
            1: vec_q[a] = off + n + $urandom_range(0, 1100);
            2: vec_q[a] = MISSING_MARK;
            3: vec_q[a] = off - 1 - $urandom_range(0, 5000);
            default:
            begin
                for (k = 0; k < n; k++)
                    vec_q[k] = $urandom;
            end
        endcase
    endtask

    initial
    begin
        int          p;
        int          n;
        int          phase_items;
        logic [31:0] off;

        start           <= 1'b0;
        element_value   <= '0;
        last_element    <= 1'b0;
        index_offset_we <= 1'b0;
        index_offset    <= '0;
        quiet            = 1'b0;
        rst_n           <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: offset zero
        vec_q = '{32'd0};                    send_vec();
        vec_q = '{32'd1};                    send_vec();
        vec_q = '{32'd0, 32'd1};             send_vec();
        vec_q = '{32'd1, 32'd0};             send_vec();
        vec_q = '{32'd1, 32'd2, 32'd0};      send_vec();
        vec_q = '{32'd0, 32'd0};             send_vec();
        vec_q = '{32'd2, 32'd0};             send_vec();
        vec_q = '{MISSING_MARK};             send_vec();
        vec_q = '{32'hFFFF_FFFF, 32'd0};     send_vec();
        vec_q = '{32'h7FFF_FFFF};            send_vec();
        vec_q = '{32'd1024};                 send_vec();

        // directed: one-based, extreme offsets, most negative offset
        set_offset(32'd1);
        vec_q = '{32'd1};                    send_vec();
        vec_q = '{32'd2, 32'd1};             send_vec();
        set_offset(32'h7FFF_FFFF);
        vec_q = '{32'h7FFF_FFFF};            send_vec();
        vec_q = '{32'h8000_0000};            send_vec();
        set_offset(32'h8000_0001);
        vec_q = '{32'h8000_0001};            send_vec();
        vec_q = '{32'h8000_0000};            send_vec();
        set_offset(32'h8000_0000);
        vec_q = '{32'h8000_0001};            send_vec();
        vec_q = '{32'h8000_0002, 32'h8000_0001}; send_vec();

        // random phases, one offset setting each
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0: off = 32'd0;
                1: off = 32'd1;
                2: off = 32'hFFFF_FFFF;
                3: off = 32'h7FFF_FFFF;
                4: off = 32'h8000_0001;
                5: off = 32'd0;
                6: off = $urandom;
                default: off = $urandom_range(0, 7);
            endcase
            set_offset(off);
            quiet = (p == 1);

            // oversized vector once
            if (p == PHASE_COUNT - 1)
            begin
                build_perm(MAX_N, off);
                repeat ($urandom_range(1, 3)) vec_q.push_back(off + $urandom_range(0, 3));
                send_vec();
            end

            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(99) < 80)
                    n = $urandom_range(1, 8);
                else if ($urandom_range(99) < 85)
                    n = $urandom_range(9, 40);
                else
                    n = $urandom_range(41, 200);
                build_perm(n, off);
                if ($urandom_range(99) < 30)
                    break_vec($urandom_range(4), off);
                send_vec();
                phase_items += n;
                if ($urandom_range(99) < 3)
                    drain();
            end
        end

        // let everything come back, then a little longer
        drain();
        repeat (100) @(posedge clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
